>>> hdl/sdpq_pkg.sv
// ----------------------------------------------------------------------------
// sdpq_pkg
// Types, widths and codes shared by the semantic drop packet queue.
// ----------------------------------------------------------------------------
package sdpq_pkg;

  localparam int DEPTH_DEF = 64;

  localparam int TAG_W   = 16;
  localparam int LEN_W   = 16;
  localparam int RATE_W  = 32;
  localparam int MSG_W   = 32;
  localparam int PRIO_W  = 8;
  localparam int POS_W   = 2;
  localparam int BYTE_W  = 22;
  localparam int PCNT_W  = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 22;

  localparam logic [BYTE_W-1:0] BYTE_MAX = {BYTE_W{1'b1}};

  localparam logic [POS_W-1:0] POS_FIRST = 2'd0;
  localparam logic [POS_W-1:0] POS_LAST  = 2'd2;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PACKET_LIMIT = 2'd1;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [LEN_W-1:0]  len;
    logic [MSG_W-1:0]  msg;
    logic [PRIO_W-1:0] prio;
    logic [POS_W-1:0]  pos;
    logic              udp;
  } slot_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEQ,
    ST_P_ORD,
    ST_P_ODAT,
    ST_P_IRD,
    ST_P_IDAT,
    ST_C_RD,
    ST_C_DAT
  } state_t;

endpackage

>>> hdl/sdpq_ram.sv
// ----------------------------------------------------------------------------
// sdpq_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sdpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/semantic_drop_packet_queue.sv
// ----------------------------------------------------------------------------
// semantic_drop_packet_queue
// Ordered packet queue in a ring RAM with limit drops and stale-message purge.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  input    | start / busy         | in_opcode .. in_prio_level
//  result   | out_valid (strobe)   | out_accepted .. out_queued_bytes
//  config   | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// a plain enqueue or a drop finishes in idle, a dequeue adds one ram read (deq)
// a preempting enqueue walks the queue: each entry is read (p_ord, p_odat), and a
// candidate entry scans all n entries (p_ird, p_idat), then compaction reads
// each entry again and slides survivors down (c_rd, c_dat)
// the result strobe comes the cycle after the last step; busy is low again
// in that cycle. reset clears counts, head and limits; ram contents need none
module semantic_drop_packet_queue
  import sdpq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_opcode,
  input  logic [TAG_W-1:0]      in_packet_tag,
  input  logic [LEN_W-1:0]      in_pkt_bytes,
  input  logic                  in_is_udp,
  input  logic [RATE_W-1:0]     in_stream_bitrate,
  input  logic [RATE_W-1:0]     in_link_bandwidth,
  input  logic [POS_W-1:0]      in_pkt_pos,
  input  logic                  in_is_preempt,
  input  logic [MSG_W-1:0]      in_msg_number,
  input  logic [PRIO_W-1:0]     in_prio_level,
  output logic                  out_valid,
  output logic                  out_accepted,
  output logic                  out_dropped_full,
  output logic                  out_dropped_rate,
  output logic [PCNT_W-1:0]     out_purged_count,
  output logic                  out_deq_valid,
  output logic [TAG_W-1:0]      out_deq_tag,
  output logic [LEN_W-1:0]      out_deq_bytes,
  output logic [PCNT_W-1:0]     out_queued_packets,
  output logic [BYTE_W-1:0]     out_queued_bytes,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int NW = (CW + 1 > PCNT_W) ? CW + 1 : PCNT_W;
  localparam int SW = $bits(slot_t);

  state_t              state_r, state_nxt;
  logic [AW-1:0]       head_r, head_nxt;
  logic [CW-1:0]       total_r, total_nxt;
  logic [BYTE_W-1:0]   bytes_r, bytes_nxt;
  logic [BYTE_W-1:0]   blim_r;
  logic [PCNT_W-1:0]   plim_r;
  logic [MSG_W-1:0]    cur_msg_r, cur_msg_nxt;
  logic [PRIO_W-1:0]   cur_prio_r, cur_prio_nxt;
  logic [MSG_W-1:0]    cand_msg_r, cand_msg_nxt;
  logic [CW-1:0]       i_r, i_nxt, j_r, j_nxt, w_r, w_nxt, rm_r, rm_nxt;
  logic [1:0]          cnt_r, cnt_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_acc_r, out_acc_nxt;
  logic                out_dfull_r, out_dfull_nxt;
  logic                out_drate_r, out_drate_nxt;
  logic [PCNT_W-1:0]   out_purged_r, out_purged_nxt;
  logic                out_dvalid_r, out_dvalid_nxt;
  logic [TAG_W-1:0]    out_dtag_r, out_dtag_nxt;
  logic [LEN_W-1:0]    out_dbytes_r, out_dbytes_nxt;
  logic [PCNT_W-1:0]   out_qpk_r, out_qpk_nxt;
  logic [BYTE_W-1:0]   out_qby_r, out_qby_nxt;

  // ram ports
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  slot_t               ram_wdata, ram_rdata;
  logic                kill_we, kill_wdata, kill_rdata;
  logic [AW-1:0]       kill_waddr;

  logic                accept;
  logic [NW-1:0]       np;
  logic [BYTE_W:0]     nb;
  logic                fits, store, purge;
  logic                is_end, cand;
  logic [1:0]          cnt_inc;

  // ring address of a logical position
  function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] hd,
                                              input logic [AW-1:0] ofs);
    logic [AW:0] s;
    s = {1'b0, hd} + {1'b0, ofs};
    if (s >= (AW+1)'(QUEUE_DEPTH)) begin
      s = s - (AW+1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  sdpq_ram #(.WIDTH(SW), .DEPTH(QUEUE_DEPTH)) u_slot_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  sdpq_ram #(.WIDTH(1), .DEPTH(QUEUE_DEPTH)) u_kill_ram (
    .clk     (clk),
    .wr_en   (kill_we),
    .wr_addr (kill_waddr),
    .wr_data (kill_wdata),
    .rd_en   (ram_re),
    .rd_addr (i_r[AW-1:0]),
    .rd_data (kill_rdata)
  );

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign np = NW'(total_r) + NW'(1);
  assign nb = {1'b0, bytes_r} + (BYTE_W+1)'(in_pkt_bytes);
  assign fits = (np <= NW'(QUEUE_DEPTH)) && (nb <= {1'b0, BYTE_MAX}) &&
                ((plim_r == '0) || (np <= NW'(plim_r))) &&
                ((blim_r == '0) || (nb <= {1'b0, blim_r}));
  assign store = !in_is_udp || (in_link_bandwidth > in_stream_bitrate);
  assign purge = in_is_udp && (in_pkt_pos == POS_LAST) && in_is_preempt;

  assign cand   = ram_rdata.udp && (ram_rdata.msg < cur_msg_r) &&
                  (ram_rdata.prio >= cur_prio_r);
  assign is_end = ram_rdata.udp && (ram_rdata.msg == cand_msg_r) &&
                  ((ram_rdata.pos == POS_FIRST) || (ram_rdata.pos == POS_LAST));
  // two ends are enough, so the count saturates
  assign cnt_inc = (is_end && cnt_r != 2'd2) ? cnt_r + 2'd1 : cnt_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_opcode == OP_DEQ) begin
            if (total_r != '0) state_nxt = ST_DEQ;
          end else if (fits && purge) begin
            state_nxt = ST_P_ORD;
          end
        end
      end
      ST_DEQ:    state_nxt = ST_IDLE;
      ST_P_ORD:  state_nxt = (i_r == total_r) ? ST_C_RD : ST_P_ODAT;
      ST_P_ODAT: state_nxt = cand ? ST_P_IRD : ST_P_ORD;
      ST_P_IRD:  state_nxt = ST_P_IDAT;
      ST_P_IDAT: state_nxt = (j_r + CW'(1) == total_r) ? ST_P_ORD : ST_P_IRD;
      ST_C_RD:   state_nxt = (i_r == total_r) ? ST_IDLE : ST_C_DAT;
      ST_C_DAT:  state_nxt = ST_C_RD;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    head_nxt       = head_r;
    total_nxt      = total_r;
    bytes_nxt      = bytes_r;
    cur_msg_nxt    = cur_msg_r;
    cur_prio_nxt   = cur_prio_r;
    cand_msg_nxt   = cand_msg_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    w_nxt          = w_r;
    rm_nxt         = rm_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = 1'b0;
    out_acc_nxt    = out_acc_r;
    out_dfull_nxt  = out_dfull_r;
    out_drate_nxt  = out_drate_r;
    out_purged_nxt = out_purged_r;
    out_dvalid_nxt = out_dvalid_r;
    out_dtag_nxt   = out_dtag_r;
    out_dbytes_nxt = out_dbytes_r;
    out_qpk_nxt    = out_qpk_r;
    out_qby_nxt    = out_qby_r;
    ram_we         = 1'b0;
    ram_waddr      = ring_addr(head_r, total_r[AW-1:0]);
    ram_wdata      = '{tag: in_packet_tag, len: in_pkt_bytes, msg: in_msg_number,
                       prio: in_prio_level, pos: in_pkt_pos, udp: in_is_udp};
    ram_re         = 1'b0;
    ram_raddr      = ring_addr(head_r, i_r[AW-1:0]);
    kill_we        = 1'b0;
    kill_waddr     = i_r[AW-1:0];
    kill_wdata     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_acc_nxt    = 1'b0;
          out_dfull_nxt  = 1'b0;
          out_drate_nxt  = 1'b0;
          out_purged_nxt = '0;
          out_dvalid_nxt = 1'b0;
          out_dtag_nxt   = '0;
          out_dbytes_nxt = '0;
          cur_msg_nxt    = in_msg_number;
          cur_prio_nxt   = in_prio_level;
          i_nxt          = '0;
          if (in_opcode == OP_DEQ) begin
            if (total_r == '0) begin
              out_valid_nxt = 1'b1;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = head_r;
            end
          end else if (!fits) begin
            out_dfull_nxt = 1'b1;
            out_valid_nxt = 1'b1;
          end else begin
            if (store) begin
              ram_we      = 1'b1;
              total_nxt   = np[CW-1:0];
              bytes_nxt   = nb[BYTE_W-1:0];
              out_acc_nxt = 1'b1;
            end else begin
              out_drate_nxt = 1'b1;
            end
            if (!purge) out_valid_nxt = 1'b1;
          end
        end
      end
      ST_DEQ: begin
        out_dvalid_nxt = 1'b1;
        out_dtag_nxt   = ram_rdata.tag;
        out_dbytes_nxt = ram_rdata.len;
        head_nxt       = ring_addr(head_r, AW'(1));
        total_nxt      = total_r - CW'(1);
        bytes_nxt      = bytes_r - BYTE_W'(ram_rdata.len);
        out_valid_nxt  = 1'b1;
      end
      ST_P_ORD: begin
        if (i_r == total_r) begin
          i_nxt  = '0;
          w_nxt  = '0;
          rm_nxt = '0;
        end else begin
          ram_re = 1'b1;
        end
      end
      ST_P_ODAT: begin
        if (cand) begin
          cand_msg_nxt = ram_rdata.msg;
          j_nxt        = '0;
          cnt_nxt      = '0;
        end else begin
          kill_we = 1'b1;
          i_nxt   = i_r + CW'(1);
        end
      end
      ST_P_IRD: begin
        ram_re    = 1'b1;
        ram_raddr = ring_addr(head_r, j_r[AW-1:0]);
      end
      ST_P_IDAT: begin
        cnt_nxt = cnt_inc;
        j_nxt   = j_r + CW'(1);
        if (j_r + CW'(1) == total_r) begin
          kill_we    = 1'b1;
          kill_wdata = (cnt_inc == 2'd2);
          i_nxt      = i_r + CW'(1);
        end
      end
      ST_C_RD: begin
        if (i_r == total_r) begin
          total_nxt      = w_r;
          out_purged_nxt = PCNT_W'(rm_r);
          out_valid_nxt  = 1'b1;
        end else begin
          ram_re = 1'b1;
        end
      end
      ST_C_DAT: begin
        i_nxt = i_r + CW'(1);
        if (kill_rdata) begin
          bytes_nxt = bytes_r - BYTE_W'(ram_rdata.len);
          rm_nxt    = rm_r + CW'(1);
        end else begin
          // slide survivors down over the removed entries
          if (w_r != i_r) begin
            ram_we    = 1'b1;
            ram_waddr = ring_addr(head_r, w_r[AW-1:0]);
            ram_wdata = ram_rdata;
          end
          w_nxt = w_r + CW'(1);
        end
      end
      default: ;
    endcase

    if (out_valid_nxt) begin
      out_qpk_nxt = PCNT_W'(total_nxt);
      out_qby_nxt = bytes_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      total_r     <= '0;
      bytes_r     <= '0;
      blim_r      <= '0;
      plim_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      total_r     <= total_nxt;
      bytes_r     <= bytes_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BYTE_LIMIT:   blim_r <= cfg_data[BYTE_W-1:0];
          CFG_PACKET_LIMIT: plim_r <= cfg_data[PCNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_msg_r    <= cur_msg_nxt;
    cur_prio_r   <= cur_prio_nxt;
    cand_msg_r   <= cand_msg_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    w_r          <= w_nxt;
    rm_r         <= rm_nxt;
    cnt_r        <= cnt_nxt;
    out_acc_r    <= out_acc_nxt;
    out_dfull_r  <= out_dfull_nxt;
    out_drate_r  <= out_drate_nxt;
    out_purged_r <= out_purged_nxt;
    out_dvalid_r <= out_dvalid_nxt;
    out_dtag_r   <= out_dtag_nxt;
    out_dbytes_r <= out_dbytes_nxt;
    out_qpk_r    <= out_qpk_nxt;
    out_qby_r    <= out_qby_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_accepted       = out_acc_r;
  assign out_dropped_full   = out_dfull_r;
  assign out_dropped_rate   = out_drate_r;
  assign out_purged_count   = out_purged_r;
  assign out_deq_valid      = out_dvalid_r;
  assign out_deq_tag        = out_dtag_r;
  assign out_deq_bytes      = out_dbytes_r;
  assign out_queued_packets = out_qpk_r;
  assign out_queued_bytes   = out_qby_r;

endmodule

>>> test/tb_semantic_drop_packet_queue.sv
// ----------------------------------------------------------------------------
// tb_semantic_drop_packet_queue
// Self-checking bench for the semantic drop packet queue. A driver feeds
// enqueue and dequeue words with random gaps. A clocked predictor keeps its
// own copy of the queue and works out each result. A monitor compares every
// result strobe, field by field, with the oldest predicted result. Limits
// are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_semantic_drop_packet_queue;
  import sdpq_pkg::*;

  localparam int NSLOT = DEPTH_DEF;

  typedef struct {
    logic              op;
    logic [TAG_W-1:0]  tag;
    logic [LEN_W-1:0]  len;
    logic              udp;
    logic [RATE_W-1:0] rate;
    logic [RATE_W-1:0] bw;
    logic [POS_W-1:0]  pos;
    logic              pre;
    logic [MSG_W-1:0]  msg;
    logic [PRIO_W-1:0] prio;
  } word_t;

  typedef struct {
    logic              accepted;
    logic              dfull;
    logic              drate;
    logic [PCNT_W-1:0] purged;
    logic              dvalid;
    logic [TAG_W-1:0]  dtag;
    logic [LEN_W-1:0]  dbytes;
    logic [PCNT_W-1:0] qpkts;
    logic [BYTE_W-1:0] qbytes;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_opcode = 1'b0;
  logic [TAG_W-1:0] in_packet_tag = '0;
  logic [LEN_W-1:0] in_pkt_bytes = '0;
  logic in_is_udp = 1'b0;
  logic [RATE_W-1:0] in_stream_bitrate = '0;
  logic [RATE_W-1:0] in_link_bandwidth = '0;
  logic [POS_W-1:0] in_pkt_pos = '0;
  logic in_is_preempt = 1'b0;
  logic [MSG_W-1:0] in_msg_number = '0;
  logic [PRIO_W-1:0] in_prio_level = '0;
  logic out_valid, out_accepted, out_dropped_full, out_dropped_rate, out_deq_valid;
  logic [PCNT_W-1:0] out_purged_count, out_queued_packets;
  logic [TAG_W-1:0] out_deq_tag;
  logic [LEN_W-1:0] out_deq_bytes;
  logic [BYTE_W-1:0] out_queued_bytes;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  semantic_drop_packet_queue u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_packet_tag(in_packet_tag), .in_pkt_bytes(in_pkt_bytes),
    .in_is_udp(in_is_udp), .in_stream_bitrate(in_stream_bitrate),
    .in_link_bandwidth(in_link_bandwidth), .in_pkt_pos(in_pkt_pos),
    .in_is_preempt(in_is_preempt), .in_msg_number(in_msg_number),
    .in_prio_level(in_prio_level), .out_valid(out_valid), .out_accepted(out_accepted),
    .out_dropped_full(out_dropped_full), .out_dropped_rate(out_dropped_rate),
    .out_purged_count(out_purged_count), .out_deq_valid(out_deq_valid),
    .out_deq_tag(out_deq_tag), .out_deq_bytes(out_deq_bytes),
    .out_queued_packets(out_queued_packets), .out_queued_bytes(out_queued_bytes),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  word_t    pending_words[$];
  verdict_t due_results[$];
  int       errors = 0;
  int       gap = 0;
  bit       word_taken = 0;
  bit       cfg_taken = 0;

  // shadow queue and limits
  slot_t       shadow_slot[NSLOT];
  int unsigned shadow_cnt = 0;
  int unsigned shadow_bytes = 0;
  int unsigned lim_bytes = 0;
  int unsigned lim_pkts = 0;

  task automatic report(input string field, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  task automatic predict_queue(input word_t w, output verdict_t r);
    int unsigned np, nb, wr, ends, removed;
    bit fits;
    bit kill[NSLOT];
    r = '{default: '0};
    if (w.op == OP_DEQ) begin
      if (shadow_cnt > 0) begin
        r.dvalid = 1'b1;
        r.dtag = shadow_slot[0].tag;
        r.dbytes = shadow_slot[0].len;
        for (int i = 1; i < shadow_cnt; i++) shadow_slot[i-1] = shadow_slot[i];
        shadow_cnt--;
        shadow_bytes -= shadow_slot[0].len == r.dbytes ? r.dbytes : r.dbytes;
      end
    end else begin
      np = shadow_cnt + 1;
      nb = shadow_bytes + w.len;
      fits = np <= NSLOT && nb <= BYTE_MAX && (lim_pkts == 0 || np <= lim_pkts) &&
             (lim_bytes == 0 || nb <= lim_bytes);
      if (!fits) begin
        r.dfull = 1'b1;
      end else begin
        if (!w.udp || w.bw > w.rate) begin
          shadow_slot[shadow_cnt] = '{tag: w.tag, len: w.len, msg: w.msg, prio: w.prio,
                                      pos: w.pos, udp: w.udp};
          shadow_cnt = np;
          shadow_bytes = nb;
          r.accepted = 1'b1;
        end else begin
          r.drate = 1'b1;
        end
        if (w.udp && w.pos == POS_LAST && w.pre) begin
          // stale message needs both ends queued, counted before removal
          for (int i = 0; i < shadow_cnt; i++) begin
            ends = 0;
            for (int j = 0; j < shadow_cnt; j++)
              if (shadow_slot[j].udp && shadow_slot[j].msg == shadow_slot[i].msg &&
                  (shadow_slot[j].pos == POS_FIRST || shadow_slot[j].pos == POS_LAST))
                ends++;
            kill[i] = shadow_slot[i].udp && shadow_slot[i].msg < w.msg &&
                      shadow_slot[i].prio >= w.prio && ends >= 2;
          end
          wr = 0;
          removed = 0;
          for (int i = 0; i < shadow_cnt; i++) begin
            if (kill[i]) begin
              shadow_bytes -= shadow_slot[i].len;
              removed++;
            end else begin
              shadow_slot[wr] = shadow_slot[i];
              wr++;
            end
          end
          shadow_cnt = wr;
          r.purged = removed[PCNT_W-1:0];
        end
      end
    end
    r.qpkts = shadow_cnt[PCNT_W-1:0];
    r.qbytes = shadow_bytes[BYTE_W-1:0];
  endtask

  // predictor and monitor
  always @(posedge clk) begin
    word_t w;
    verdict_t r, e;
    word_taken = rst_n && start && !busy;
    cfg_taken = rst_n && cfg_valid && cfg_ready;
    if (rst_n && out_valid) begin
      if (due_results.size() == 0) begin
        report("result with nothing due", 1, 0);
      end else begin
        e = due_results[0];
        due_results.delete(0);
        if (out_accepted !== e.accepted) report("accepted", out_accepted, e.accepted);
        if (out_dropped_full !== e.dfull) report("dropped_full", out_dropped_full, e.dfull);
        if (out_dropped_rate !== e.drate) report("dropped_rate", out_dropped_rate, e.drate);
        if (out_purged_count !== e.purged) report("purged_count", out_purged_count, e.purged);
        if (out_deq_valid !== e.dvalid) report("deq_valid", out_deq_valid, e.dvalid);
        if (out_deq_tag !== e.dtag) report("deq_tag", out_deq_tag, e.dtag);
        if (out_deq_bytes !== e.dbytes) report("deq_bytes", out_deq_bytes, e.dbytes);
        if (out_queued_packets !== e.qpkts)
          report("queued_packets", out_queued_packets, e.qpkts);
        if (out_queued_bytes !== e.qbytes) report("queued_bytes", out_queued_bytes, e.qbytes);
      end
    end
    if (word_taken) begin
      w = '{op: in_opcode, tag: in_packet_tag, len: in_pkt_bytes, udp: in_is_udp,
            rate: in_stream_bitrate, bw: in_link_bandwidth, pos: in_pkt_pos,
            pre: in_is_preempt, msg: in_msg_number, prio: in_prio_level};
      predict_queue(w, r);
      due_results.push_back(r);
    end
  end

  // driver
  always @(negedge clk) begin
    word_t w;
    if (rst_n && !(start && !word_taken)) begin
      if (gap > 0) begin
        gap <= gap - 1;
        start <= 1'b0;
      end else if (pending_words.size() > 0) begin
        w = pending_words[0];
        pending_words.delete(0);
        in_opcode <= w.op;
        in_packet_tag <= w.tag;
        in_pkt_bytes <= w.len;
        in_is_udp <= w.udp;
        in_stream_bitrate <= w.rate;
        in_link_bandwidth <= w.bw;
        in_pkt_pos <= w.pos;
        in_is_preempt <= w.pre;
        in_msg_number <= w.msg;
        in_prio_level <= w.prio;
        start <= 1'b1;
        gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      end else begin
        start <= 1'b0;
      end
    end
  end

  function automatic word_t deq_word();
    word_t w;
    w = '{default: '0};
    w.op = OP_DEQ;
    w.tag = TAG_W'($urandom);
    w.len = LEN_W'($urandom);
    return w;
  endfunction

  function automatic word_t enq_word(input logic udp, input logic [RATE_W-1:0] rate,
                                     input logic [RATE_W-1:0] bw, input logic [POS_W-1:0] pos,
                                     input logic pre, input logic [MSG_W-1:0] msg,
                                     input logic [PRIO_W-1:0] prio,
                                     input logic [LEN_W-1:0] len);
    word_t w;
    w.op = OP_ENQ;
    w.tag = TAG_W'($urandom);
    w.len = len;
    w.udp = udp;
    w.rate = rate;
    w.bw = bw;
    w.pos = pos;
    w.pre = pre;
    w.msg = msg;
    w.prio = prio;
    return w;
  endfunction

  task automatic drain();
    while (pending_words.size() > 0 || due_results.size() > 0 || start) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
    if (idx == CFG_BYTE_LIMIT) lim_bytes = val & BYTE_MAX;
    else lim_pkts = val & 7'h7f;
  endtask

  function automatic logic [LEN_W-1:0] rand_len();
    case ($urandom_range(0, 3))
      0: return LEN_W'($urandom);
      1: return LEN_W'($urandom_range(0, 1));
      default: return LEN_W'($urandom_range(0, 2000));
    endcase
  endfunction

  // one burst of random traffic: mostly whole messages, some dequeues and noise
  task automatic random_traffic(input int n, input int deq_pct);
    int made;
    int unsigned msg_base, plen, msg, prio, bw, rate;
    made = 0;
    msg_base = $urandom_range(0, 100);
    while (made < n) begin
      if ($urandom_range(0, 99) < deq_pct) begin
        pending_words.push_back(deq_word());
        made++;
      end else if ($urandom_range(0, 99) < 80) begin
        msg_base += $urandom_range(0, 2);
        msg = msg_base - $urandom_range(0, 1);
        prio = $urandom_range(0, 5);
        plen = $urandom_range(1, 4);
        for (int k = 0; k < plen; k++) begin
          rate = $urandom_range(0, 1000);
          bw = ($urandom_range(0, 5) == 0) ? rate - $urandom_range(0, 1) : rate + 1;
          pending_words.push_back(enq_word($urandom_range(0, 9) != 0, rate, bw,
              plen == 1 ? 2'd3 : (k == 0 ? POS_FIRST : (k == plen - 1 ? POS_LAST : 2'd1)),
              $urandom_range(0, 2) == 0, msg, PRIO_W'(prio), rand_len()));
        end
        made += plen;
      end else begin
        pending_words.push_back(enq_word(1'($urandom), $urandom, $urandom,
                                         POS_W'($urandom), 1'($urandom), $urandom,
                                         PRIO_W'($urandom), LEN_W'($urandom)));
        made++;
      end
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty pop, extremes, rate drop, stale purge
    pending_words.push_back(deq_word());
    pending_words.push_back(enq_word(1'b0, '1, '0, 2'd3, 1'b1, '1, '1, '1));
    pending_words.push_back(enq_word(1'b1, 32'd100, 32'd101, POS_FIRST, 1'b0, 32'd5, 8'd10, 16'd0));
    pending_words.push_back(enq_word(1'b1, 32'd100, 32'd100, 2'd1, 1'b0, 32'd5, 8'd10, 16'd7));
    pending_words.push_back(enq_word(1'b1, 32'd0, '1, POS_LAST, 1'b0, 32'd5, 8'd10, 16'd9));
    pending_words.push_back(enq_word(1'b1, 32'd1, 32'd2, POS_FIRST, 1'b0, 32'd6, 8'd2, 16'd3));
    pending_words.push_back(enq_word(1'b1, 32'd1, 32'd2, POS_LAST, 1'b0, 32'd6, 8'd2, 16'd3));
    // dropped preempting packet still purges message 5
    pending_words.push_back(enq_word(1'b1, '1, '1, POS_LAST, 1'b1, 32'd9, 8'd3, 16'd4));
    // accepted preemptor, equal priority purges message 6
    pending_words.push_back(enq_word(1'b1, 32'd0, 32'd1, POS_LAST, 1'b1, 32'd9, 8'd2, 16'd4));
    pending_words.push_back(enq_word(1'b1, 32'd0, 32'd1, 2'd3, 1'b1, '1, 8'd0, 16'd1));
    for (int i = 0; i < 4; i++) pending_words.push_back(deq_word());
    drain();

    // depth limit: fill past 64 with max length, then a preempting word is dropped as full
    for (int i = 0; i < 66; i++)
      pending_words.push_back(enq_word(1'(i % 2), 32'd0, 32'd1,
                                       POS_W'(POS_FIRST + 2 * (i % 2)),
                                       1'b0, i / 4, 8'd200, 16'hffff));
    pending_words.push_back(enq_word(1'b1, '1, '1, POS_LAST, 1'b1, 32'd1000, 8'd0, 16'd1));
    for (int i = 0; i < 66; i++) pending_words.push_back(deq_word());
    drain();

    random_traffic(140, 45);
    drain();
    write_cfg(CFG_BYTE_LIMIT, 4194240);
    write_cfg(CFG_PACKET_LIMIT, 64);
    random_traffic(90, 35);
    drain();
    write_cfg(CFG_PACKET_LIMIT, 1);
    write_cfg(CFG_BYTE_LIMIT, 1);
    random_traffic(60, 40);
    drain();
    write_cfg(CFG_PACKET_LIMIT, 5);
    write_cfg(CFG_BYTE_LIMIT, 3000);
    random_traffic(100, 40);
    drain();
    write_cfg(CFG_PACKET_LIMIT, 0);
    write_cfg(CFG_BYTE_LIMIT, 0);
    random_traffic(100, 45);
    for (int i = 0; i < 70; i++) pending_words.push_back(deq_word());
    drain();

    if (errors == 0) begin
      $display("tb_semantic_drop_packet_queue: clean");
    end else begin
      $display("tb_semantic_drop_packet_queue: errors");
    end
    $finish;
  end

  initial begin
    #(12.0 * 20000000);
    $display("tb_semantic_drop_packet_queue: errors");
    $finish;
  end

endmodule
